// ===== hdl/sluc_pkg.sv =====
// shared types, widths and helper functions for the subnet lease utilization counter
// no dependencies; used by sluc_ctrl, sluc_dpath and the top level
`timescale 1ns / 1ps

package sluc_pkg;

  localparam int ADDR_W     = 32;
  localparam int LEN_W      = 5;
  localparam int CNT_W      = 11;
  localparam int MAX_SLOTS  = 4;
  localparam int SLOT_W     = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  // registers alternate base, length per slot: index bit 0 picks length, bits above pick slot
  localparam int CFG_NUM_REGS = 2 * MAX_SLOTS;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic load;    // capture a new request and its match mask
    logic search;  // step the linear search of the seen store
    logic commit;  // update store, counts and flags, load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic matched_any;
    logic search_done;
    logic out_free;
  } dp_status_t;

  // address lies in prefix; length zero never matches
  function automatic logic in_prefix(input logic [ADDR_W-1:0] addr,
                                     input logic [ADDR_W-1:0] base,
                                     input logic [LEN_W-1:0]  len);
    logic [ADDR_W-1:0] diff;
    logic [5:0]        sh;
    diff = addr ^ base;
    sh   = 6'd32 - {1'b0, len};
    return (len != '0) && ((diff >> sh) == '0);
  endfunction

  // 2*cnt > 2^(32-len) - 2  is the same as  cnt >= 2^(31-len)
  function automatic logic over_half(input logic [CNT_W-1:0] cnt,
                                     input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] sh;
    sh = LEN_W'(5'd31 - len);
    return (sh < LEN_W'(CNT_W)) && ((cnt >> sh) != '0);
  endfunction

endpackage

// ===== hdl/sluc_ctrl.sv =====
// controller state machine: sequences capture, store search and commit of one request
// depends on sluc_pkg for the command and status structs
`timescale 1ns / 1ps

module sluc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sluc_pkg::dp_status_t status,
  output sluc_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        // unmatched addresses skip the search entirely
        if (!status.matched_any || status.search_done) begin
          state_nxt = ST_FINISH;
        end
        cmd.search = status.matched_any;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/sluc_dpath.sv =====
// datapath: prefix registers, seen-address store with linear search, slot counts,
// threshold flags and result register; depends on sluc_pkg
`timescale 1ns / 1ps

module sluc_dpath #(
  parameter int STORE_DEPTH  = 1024,
  parameter int PREFIX_SLOTS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sluc_pkg::ctrl_cmd_t               cmd,
  output sluc_pkg::dp_status_t              status,
  input  logic                              cfg_we,
  input  logic [sluc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sluc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [sluc_pkg::ADDR_W-1:0]       in_leased_address,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sluc_pkg::MAX_SLOTS-1:0]    out_matched_mask,
  output logic [sluc_pkg::MAX_SLOTS-1:0]    out_added_mask,
  output logic [sluc_pkg::CNT_W-1:0]        out_count_slot0,
  output logic [sluc_pkg::CNT_W-1:0]        out_count_slot1,
  output logic [sluc_pkg::CNT_W-1:0]        out_count_slot2,
  output logic [sluc_pkg::CNT_W-1:0]        out_count_slot3,
  output logic [sluc_pkg::MAX_SLOTS-1:0]    out_crossed_now_mask,
  output logic [sluc_pkg::MAX_SLOTS-1:0]    out_exceeded_mask,
  output logic                              out_store_full
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int FW = $clog2(STORE_DEPTH + 1);
  localparam int NS = sluc_pkg::MAX_SLOTS;

  logic [sluc_pkg::ADDR_W-1:0] prefix_base_r [NS];
  logic [sluc_pkg::LEN_W-1:0]  prefix_len_r  [NS];
  logic [sluc_pkg::CNT_W-1:0]  count_r       [NS];
  logic [NS-1:0]               exceeded_r;
  logic [NS-1:0]               active;
  logic [NS-1:0]               present;

  logic [sluc_pkg::ADDR_W-1:0] addr_r;
  logic [NS-1:0]               matched_r;
  logic [NS-1:0]               matched_nxt;
  logic [FW-1:0]               idx_r;
  logic                        pend_r;
  logic                        found_r;
  logic [sluc_pkg::ADDR_W-1:0] rdata_r;
  logic [FW-1:0]               fill_r;

  logic [sluc_pkg::ADDR_W-1:0] store_mem [STORE_DEPTH];

  logic hit;
  logic search_done;
  logic mem_re;
  logic is_new;
  logic full;
  logic do_store;

  logic [sluc_pkg::CNT_W-1:0] cnt_nxt [NS];
  logic [NS-1:0]              added;
  logic [NS-1:0]              crossed;
  logic [NS-1:0]              exc_nxt;

  logic                       out_valid_r;
  logic [NS-1:0]              out_matched_r;
  logic [NS-1:0]              out_added_r;
  logic [sluc_pkg::CNT_W-1:0] out_count_r [NS];
  logic [NS-1:0]              out_crossed_r;
  logic [NS-1:0]              out_exceeded_r;
  logic                       out_full_r;

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      present[s]     = (s < PREFIX_SLOTS);
      active[s]      = present[s] && (prefix_len_r[s] != '0);
      matched_nxt[s] = active[s] &&
                       sluc_pkg::in_prefix(in_leased_address, prefix_base_r[s], prefix_len_r[s]);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS; s++) begin
        prefix_base_r[s] <= '0;
        prefix_len_r[s]  <= '0;
      end
    end else if (cfg_we && (cfg_index < sluc_pkg::CFG_IDX_W'(sluc_pkg::CFG_NUM_REGS))) begin
      if (cfg_index[0]) begin
        prefix_len_r[cfg_index[sluc_pkg::SLOT_W:1]]  <= cfg_wdata[sluc_pkg::LEN_W-1:0];
      end else begin
        prefix_base_r[cfg_index[sluc_pkg::SLOT_W:1]] <= cfg_wdata[sluc_pkg::ADDR_W-1:0];
      end
    end
  end

  // linear search: read issued one cycle, compared the next
  assign hit         = pend_r && (rdata_r == addr_r);
  assign search_done = hit || (idx_r >= fill_r);
  assign mem_re      = cmd.search && !search_done;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r    <= in_leased_address;
      matched_r <= matched_nxt;
      idx_r     <= '0;
      pend_r    <= 1'b0;
      found_r   <= 1'b0;
    end else if (cmd.search) begin
      if (search_done) begin
        found_r <= hit;
        pend_r  <= 1'b0;
      end else begin
        idx_r  <= idx_r + FW'(1);
        pend_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && do_store) begin
      store_mem[fill_r[AW-1:0]] <= addr_r;
    end
    if (mem_re) begin
      rdata_r <= store_mem[idx_r[AW-1:0]];
    end
  end

  // commit: new address, counts and threshold check on the updated counts
  assign is_new   = (matched_r != '0) && !found_r;
  assign full     = is_new && (fill_r == FW'(STORE_DEPTH));
  assign do_store = is_new && !full;

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      added[s]   = do_store && matched_r[s] && (count_r[s] != sluc_pkg::COUNT_MAX);
      cnt_nxt[s] = count_r[s] + sluc_pkg::CNT_W'(added[s]);
      crossed[s] = active[s] && !exceeded_r[s] &&
                   sluc_pkg::over_half(cnt_nxt[s], prefix_len_r[s]);
      exc_nxt[s] = exceeded_r[s] || crossed[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      exceeded_r <= '0;
      for (int s = 0; s < NS; s++) begin
        count_r[s] <= '0;
      end
    end else if (cmd.commit) begin
      if (do_store) begin
        fill_r <= fill_r + FW'(1);
      end
      exceeded_r <= exc_nxt;
      for (int s = 0; s < NS; s++) begin
        count_r[s] <= cnt_nxt[s];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_matched_r  <= matched_r;
      out_added_r    <= added;
      out_crossed_r  <= crossed;
      out_exceeded_r <= exc_nxt & present;
      out_full_r     <= full;
      for (int s = 0; s < NS; s++) begin
        out_count_r[s] <= present[s] ? cnt_nxt[s] : '0;
      end
    end
  end

  assign status.matched_any = (matched_r != '0);
  assign status.search_done = search_done;
  assign status.out_free    = !out_valid_r || !out_stall;

  assign out_valid            = out_valid_r;
  assign out_matched_mask     = out_matched_r;
  assign out_added_mask       = out_added_r;
  assign out_count_slot0      = out_count_r[0];
  assign out_count_slot1      = out_count_r[1];
  assign out_count_slot2      = out_count_r[2];
  assign out_count_slot3      = out_count_r[3];
  assign out_crossed_now_mask = out_crossed_r;
  assign out_exceeded_mask    = out_exceeded_r;
  assign out_store_full       = out_full_r;

endmodule

// ===== hdl/subnet_lease_utilization_counter.sv =====
// top level of the subnet lease utilization counter
// instantiates sluc_ctrl and sluc_dpath, types from sluc_pkg
//
//   channel  handshake            payload
//   in_      in_valid / in_stall  in_leased_address
//   out_     out_valid/out_stall  masks, four slot counts, out_store_full
//   cfg_     cfg_we               cfg_index, cfg_wdata (no read-back)
//
// a request that matches a slot and misses the store reads every stored entry,
// a hit ends the search early, a request that matches no slot skips it; the
// linear search uses the seen store's single read port, one entry per cycle
// reset clears counts, flags and the fill count; the store itself needs no clearing
// a stalled result keeps the current request in its final cycle, with the input
// stalled, until the result register frees
`timescale 1ns / 1ps

module subnet_lease_utilization_counter #(
  parameter int STORE_DEPTH  = 1024,
  parameter int PREFIX_SLOTS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sluc_pkg::ADDR_W-1:0]     in_leased_address,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sluc_pkg::MAX_SLOTS-1:0]  out_matched_mask,
  output logic [sluc_pkg::MAX_SLOTS-1:0]  out_added_mask,
  output logic [sluc_pkg::CNT_W-1:0]      out_count_slot0,
  output logic [sluc_pkg::CNT_W-1:0]      out_count_slot1,
  output logic [sluc_pkg::CNT_W-1:0]      out_count_slot2,
  output logic [sluc_pkg::CNT_W-1:0]      out_count_slot3,
  output logic [sluc_pkg::MAX_SLOTS-1:0]  out_crossed_now_mask,
  output logic [sluc_pkg::MAX_SLOTS-1:0]  out_exceeded_mask,
  output logic                            out_store_full,
  input  logic                            cfg_we,
  input  logic [sluc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sluc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  sluc_pkg::ctrl_cmd_t  cmd;
  sluc_pkg::dp_status_t status;

  sluc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sluc_dpath #(
    .STORE_DEPTH  (STORE_DEPTH),
    .PREFIX_SLOTS (PREFIX_SLOTS)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_leased_address    (in_leased_address),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_matched_mask     (out_matched_mask),
    .out_added_mask       (out_added_mask),
    .out_count_slot0      (out_count_slot0),
    .out_count_slot1      (out_count_slot1),
    .out_count_slot2      (out_count_slot2),
    .out_count_slot3      (out_count_slot3),
    .out_crossed_now_mask (out_crossed_now_mask),
    .out_exceeded_mask    (out_exceeded_mask),
    .out_store_full       (out_store_full)
  );

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for subnet_lease_utilization_counter
// depends on sluc_pkg and the rtl; predicts every result and checks it field by field
`timescale 1ns / 1ps

module tb_top;

  localparam int STORE_DEPTH = 1024;
  localparam int IDLE_LIMIT  = 12000;

  typedef enum logic [sluc_pkg::CFG_IDX_W-1:0] {
    REG_BASE_0, REG_LEN_0, REG_BASE_1, REG_LEN_1,
    REG_BASE_2, REG_LEN_2, REG_BASE_3, REG_LEN_3
  } cfg_reg_t;

  typedef struct packed {
    logic [sluc_pkg::MAX_SLOTS-1:0] matched;
    logic [sluc_pkg::MAX_SLOTS-1:0] added;
    logic [sluc_pkg::CNT_W-1:0]     count0;
    logic [sluc_pkg::CNT_W-1:0]     count1;
    logic [sluc_pkg::CNT_W-1:0]     count2;
    logic [sluc_pkg::CNT_W-1:0]     count3;
    logic [sluc_pkg::MAX_SLOTS-1:0] crossed;
    logic [sluc_pkg::MAX_SLOTS-1:0] exceeded;
    logic                           full;
  } lease_outcome_t;

  logic                            clk;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [sluc_pkg::ADDR_W-1:0]     in_leased_address = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [sluc_pkg::MAX_SLOTS-1:0]  out_matched_mask;
  logic [sluc_pkg::MAX_SLOTS-1:0]  out_added_mask;
  logic [sluc_pkg::CNT_W-1:0]      out_count_slot0;
  logic [sluc_pkg::CNT_W-1:0]      out_count_slot1;
  logic [sluc_pkg::CNT_W-1:0]      out_count_slot2;
  logic [sluc_pkg::CNT_W-1:0]      out_count_slot3;
  logic [sluc_pkg::MAX_SLOTS-1:0]  out_crossed_now_mask;
  logic [sluc_pkg::MAX_SLOTS-1:0]  out_exceeded_mask;
  logic                            out_store_full;
  logic                            cfg_we = 1'b0;
  logic [sluc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sluc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // shadow of the block's configuration and counting state
  logic [sluc_pkg::ADDR_W-1:0]    pfx_base [sluc_pkg::MAX_SLOTS];
  logic [sluc_pkg::LEN_W-1:0]     pfx_len [sluc_pkg::MAX_SLOTS];
  logic [sluc_pkg::CNT_W-1:0]     slot_count [sluc_pkg::MAX_SLOTS];
  logic [sluc_pkg::MAX_SLOTS-1:0] slot_flag;
  bit                             seen_set [bit [sluc_pkg::ADDR_W-1:0]];
  logic [sluc_pkg::ADDR_W-1:0]    stored_addrs [$];
  int                             seen_fill;

  lease_outcome_t outcome_due [$];
  lease_outcome_t want;

  int n_errors   = 0;
  int n_sent     = 0;
  int n_checked  = 0;
  int n_crossed  = 0;
  int n_dropped  = 0;
  int calm_left  = 0;
  int stall_hold = 0;
  int stall_roll;
  int idle_cycles = 0;

  subnet_lease_utilization_counter #(
    .STORE_DEPTH  (STORE_DEPTH),
    .PREFIX_SLOTS (sluc_pkg::MAX_SLOTS)
  ) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_leased_address    (in_leased_address),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_matched_mask     (out_matched_mask),
    .out_added_mask       (out_added_mask),
    .out_count_slot0      (out_count_slot0),
    .out_count_slot1      (out_count_slot1),
    .out_count_slot2      (out_count_slot2),
    .out_count_slot3      (out_count_slot3),
    .out_crossed_now_mask (out_crossed_now_mask),
    .out_exceeded_mask    (out_exceeded_mask),
    .out_store_full       (out_store_full),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    for (int s = 0; s < sluc_pkg::MAX_SLOTS; s++) begin
      pfx_base[s]   = '0;
      pfx_len[s]    = '0;
      slot_count[s] = '0;
    end
    slot_flag = '0;
    seen_fill = 0;
  end

  // expected result of one accepted request, advances the shadow state
  function automatic lease_outcome_t account_lease(input logic [sluc_pkg::ADDR_W-1:0] addr);
    lease_outcome_t r;
    logic [sluc_pkg::ADDR_W-1:0] mask;
    logic [63:0] hosts;
    logic [63:0] twice_cnt;
    r = '0;
    for (int s = 0; s < sluc_pkg::MAX_SLOTS; s++) begin
      if (pfx_len[s] != '0) begin
        mask = 32'hFFFF_FFFF << (32 - pfx_len[s]);
        if ((addr & mask) == (pfx_base[s] & mask))
          r.matched[s] = 1'b1;
      end
    end
    if (r.matched != '0 && !seen_set.exists(addr)) begin
      if (seen_fill >= STORE_DEPTH) begin
        r.full = 1'b1;
      end else begin
        seen_set[addr] = 1'b1;
        stored_addrs.push_back(addr);
        seen_fill++;
        for (int s = 0; s < sluc_pkg::MAX_SLOTS; s++) begin
          if (r.matched[s] && slot_count[s] != sluc_pkg::COUNT_MAX) begin
            slot_count[s] = slot_count[s] + 1'b1;
            r.added[s] = 1'b1;
          end
        end
      end
    end
    // half utilization: twice the count above 2^(host bits) - 2
    for (int s = 0; s < sluc_pkg::MAX_SLOTS; s++) begin
      if (pfx_len[s] != '0 && !slot_flag[s]) begin
        hosts = (64'd1 << (32 - pfx_len[s])) - 64'd2;
        twice_cnt = 64'(slot_count[s]);
        twice_cnt = twice_cnt << 1;
        if (twice_cnt > hosts) begin
          slot_flag[s] = 1'b1;
          r.crossed[s] = 1'b1;
        end
      end
    end
    r.exceeded = slot_flag;
    r.count0 = slot_count[0];
    r.count1 = slot_count[1];
    r.count2 = slot_count[2];
    r.count3 = slot_count[3];
    n_crossed += $countones(r.crossed);
    if (r.full)
      n_dropped++;
    return r;
  endfunction

  // mostly short gaps, a few long ones, and stretches without any
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_lease(input logic [sluc_pkg::ADDR_W-1:0] addr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_leased_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    outcome_due.push_back(account_lease(addr));
    n_sent++;
  endtask

  // drop the request line and let every pending result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (outcome_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // caller lowers cfg_we after the last write of a batch
  task automatic write_reg(input logic [sluc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sluc_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx < sluc_pkg::CFG_NUM_REGS) begin
      if (idx[0])
        pfx_len[idx >> 1] = data[sluc_pkg::LEN_W-1:0];
      else
        pfx_base[idx >> 1] = data;
    end
  endtask

  task automatic set_slot(input int slot, input logic [sluc_pkg::ADDR_W-1:0] base,
                          input logic [sluc_pkg::LEN_W-1:0] len);
    logic [sluc_pkg::CFG_DATA_W-1:0] len_word;
    // junk in the unused upper bits of the length word
    len_word = $urandom();
    len_word[sluc_pkg::LEN_W-1:0] = len;
    case (slot)
      0: begin
        write_reg(REG_BASE_0, base);
        write_reg(REG_LEN_0, len_word);
      end
      1: begin
        write_reg(REG_BASE_1, base);
        write_reg(REG_LEN_1, len_word);
      end
      2: begin
        write_reg(REG_BASE_2, base);
        write_reg(REG_LEN_2, len_word);
      end
      default: begin
        write_reg(REG_BASE_3, base);
        write_reg(REG_LEN_3, len_word);
      end
    endcase
  endtask

  function automatic logic [sluc_pkg::ADDR_W-1:0] pick_lease();
    logic [sluc_pkg::ADDR_W-1:0] mask;
    int s;
    int r;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, sluc_pkg::MAX_SLOTS - 1);
    mask = (pfx_len[s] == '0) ? 32'h0 : (32'hFFFF_FFFF << (32 - pfx_len[s]));
    if (r < 40) return (pfx_base[s] & mask) | ($urandom() & ~mask);
    // few host bits so the same addresses come back
    if (r < 55) return (pfx_base[s] & mask) | ($urandom_range(0, 7) & ~mask);
    if (r < 75 && stored_addrs.size() != 0)
      return stored_addrs[$urandom_range(0, stored_addrs.size() - 1)];
    if (r < 92) return $urandom();
    return r[0] ? 32'hFFFF_FFFF : 32'h0;
  endfunction

  // an address not yet in the store, inside the fresh-address prefixes
  function automatic logic [sluc_pkg::ADDR_W-1:0] fresh_lease();
    logic [sluc_pkg::ADDR_W-1:0] a;
    do begin
      if ($urandom_range(0, 99) < 70)
        a = 32'h0A00_0000 | $urandom_range(0, 1023);
      else
        a = 32'h0A01_0000 | $urandom_range(0, 65535);
    end while (seen_set.exists(a));
    return a;
  endfunction

  task automatic report_mismatch(input string what);
    if (n_errors < 40)
      $display("%0t mismatch: %s", $time, what);
    n_errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, exp_val));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (outcome_due.size() == 0) begin
        report_mismatch("result with no request waiting");
      end else begin
        want = outcome_due.pop_front();
        n_checked++;
        check_field("matched_mask", 32'(out_matched_mask), 32'(want.matched));
        check_field("added_mask", 32'(out_added_mask), 32'(want.added));
        check_field("count_slot0", 32'(out_count_slot0), 32'(want.count0));
        check_field("count_slot1", 32'(out_count_slot1), 32'(want.count1));
        check_field("count_slot2", 32'(out_count_slot2), 32'(want.count2));
        check_field("count_slot3", 32'(out_count_slot3), 32'(want.count3));
        check_field("crossed_now_mask", 32'(out_crossed_now_mask), 32'(want.crossed));
        check_field("exceeded_mask", 32'(out_exceeded_mask), 32'(want.exceeded));
        check_field("store_full", 32'(out_store_full), 32'(want.full));
      end
    end
  end

  // result side back-pressure: runs, short stalls, a few long ones
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 50) begin
        out_stall  <= 1'b0;
        stall_hold <= (stall_roll < 5) ? $urandom_range(30, 100) : $urandom_range(0, 6);
      end else begin
        out_stall <= 1'b1;
        if (stall_roll > 96)
          stall_hold <= $urandom_range(40, 120);
        else if (stall_roll > 85)
          stall_hold <= $urandom_range(4, 15);
        else
          stall_hold <= $urandom_range(0, 2);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: nothing moved for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // after reset every slot is disabled
  task automatic test_unconfigured();
    send_lease(32'h0000_0000);
    send_lease(32'hFFFF_FFFF);
    send_lease($urandom());
  endtask

  task automatic test_overlap_and_repeat();
    wait_idle();
    set_slot(0, 32'h0A00_0000, 5'd24);
    set_slot(1, 32'h0A00_0000, 5'd16);
    set_slot(2, 32'hC0A8_0100, 5'd30);
    set_slot(3, 32'hFFFF_FFFF, 5'd31);
    cfg_we <= 1'b0;
    send_lease(32'h0A00_0001);
    send_lease(32'h0A00_0001);
    send_lease(32'h0A00_FF05);
    send_lease(32'h0000_0000);
    send_lease(32'h7FFF_FFFF);
  endtask

  task automatic test_threshold_crossing();
    send_lease(32'hC0A8_0101);
    send_lease(32'hC0A8_0102);
    send_lease(32'hC0A8_0103);
    // a /31 has no usable hosts, so the first address flags it
    send_lease(32'hFFFF_FFFF);
    send_lease(32'hFFFF_FFFE);
  endtask

  task automatic test_reconfigure();
    logic [sluc_pkg::CFG_IDX_W-1:0] stray_idx;
    wait_idle();
    set_slot(2, 32'h0A00_0000, 5'd8);
    set_slot(3, 32'hFFFF_FFFF, 5'd0);
    set_slot(1, 32'h0000_0000, 5'd1);
    stray_idx = sluc_pkg::CFG_IDX_W'(sluc_pkg::CFG_NUM_REGS + $urandom_range(0, 7));
    write_reg(stray_idx, $urandom());
    cfg_we <= 1'b0;
    // stored already, so the newly matching slot gains nothing
    send_lease(32'h0A00_0001);
    send_lease(32'hFFFF_FFFF);
    send_lease(32'h0000_0000);
    send_lease(32'h0A00_0002);
    wait_idle();
    // count already above what a /30 allows, flag comes on an unmatched request
    set_slot(1, 32'h1234_5678, 5'd30);
    cfg_we <= 1'b0;
    send_lease(32'hC000_0000);
  endtask

  task automatic test_random_settings();
    int r;
    logic [sluc_pkg::LEN_W-1:0] len;
    for (int k = 0; k < 5; k++) begin
      wait_idle();
      if (k == 0) begin
        set_slot(0, 32'h0000_0000, 5'd31);
        set_slot(1, 32'hFFFF_FFFF, 5'd1);
        set_slot(2, $urandom(), 5'd28);
        set_slot(3, $urandom(), 5'd0);
      end else begin
        for (int s = 0; s < sluc_pkg::MAX_SLOTS; s++) begin
          r = $urandom_range(0, 99);
          if (r < 10) len = 5'd0;
          else if (r < 20) len = 5'd1;
          else if (r < 35) len = 5'd31;
          else len = sluc_pkg::LEN_W'($urandom_range(20, 30));
          set_slot(s, $urandom(), len);
        end
      end
      cfg_we <= 1'b0;
      for (int i = 0; i < 100; i++) begin
        if (k == 2 && i == 50)
          wait_idle();
        send_lease(pick_lease());
      end
    end
  endtask

  // a burst of new addresses followed by new, repeated and unmatched requests
  task automatic test_fresh_and_repeats();
    wait_idle();
    set_slot(0, 32'h0A00_0000, 5'd24);
    set_slot(1, 32'h0A00_0000, 5'd22);
    set_slot(2, 32'h0A01_0000, 5'd16);
    set_slot(3, 32'h0000_0000, 5'd1);
    cfg_we <= 1'b0;
    repeat (40)
      send_lease(fresh_lease());
    for (int i = 0; i < 30; i++) begin
      case (i % 3)
        0: send_lease(fresh_lease());
        1: send_lease(stored_addrs[$urandom_range(0, stored_addrs.size() - 1)]);
        default: send_lease($urandom() | 32'h8000_0000);
      endcase
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unconfigured();
    test_overlap_and_repeat();
    test_threshold_crossing();
    test_reconfigure();
    test_random_settings();
    test_fresh_and_repeats();
    wait_idle();
    repeat (64) @(posedge clk);
    $display("%0d lease requests sent, %0d results checked, store holds %0d of %0d",
             n_sent, n_checked, seen_fill, STORE_DEPTH);
    $display("%0d threshold crossings, %0d new addresses dropped on a full store",
             n_crossed, n_dropped);
    if (n_errors == 0 && outcome_due.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
